// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the checksum block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks an implication or plain property on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== hw/rtl/ihc_pkg.sv =====
// Package with widths, types and helpers of the IPv4 header checksum lane block.
package ihc_pkg;

  localparam int DATA_W    = 64;
  localparam int KEEP_W    = 8;
  localparam int LANE_W    = 16;
  localparam int NUM_LANES = DATA_W / LANE_W;
  localparam int HLEN_W    = 4;
  localparam int IN_W      = DATA_W + KEEP_W;
  localparam int OUT_W     = DATA_W + KEEP_W + NUM_LANES * LANE_W;

  typedef logic [LANE_W-1:0] lane_t;

  // Position of a word within the packet header.
  typedef enum logic [1:0] {
    WS_FIRST,
    WS_SECOND,
    WS_REST
  } word_pos_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [KEEP_W-1:0] keep;
    logic              last;
  } in_word_t;

  typedef struct packed {
    lane_t [NUM_LANES-1:0] sums;
    logic                  sums_valid;
    logic [DATA_W-1:0]     data;
    logic [KEEP_W-1:0]     keep;
    logic                  last;
  } result_t;

  // Ones' complement addition with end-around carry.
  function automatic lane_t ones_add(input lane_t a, input lane_t b);
    logic [LANE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LANE_W-1:0] + {{(LANE_W-1){1'b0}}, s[LANE_W]};
  endfunction

endpackage

// ===== hw/rtl/ipv4_header_checksum_lanes_top.sv =====
// Top level of the IPv4 header checksum lane block with its output register.
// An accepted input word passes through the input register and then the output register.
// Throughput: one word per cycle while the output is not stalled, set by the input and output registers.
// Reset (rst, synchronous) clears the sums, the word position and skip_checksum.
// The header length count is loaded by each packet's first word and needs no reset.
`include "assert_macros.svh"
module ipv4_header_checksum_lanes_top import ihc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0: data_in[63:0], keep_in[71:64].
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // Fields from bit 0: data_out[63:0], keep_out[71:64], lane_sum_0[87:72],
  // lane_sum_1[103:88], lane_sum_2[119:104], lane_sum_3[135:120].
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tlast,
  // Fields from bit 0: sums_valid.
  output logic             m_axis_tuser,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);

  in_word_t in_word;
  in_word_t held_word;
  result_t  result;
  result_t  out_q;
  logic     in_full;
  logic     out_space;
  logic     fire;
  logic     skip_checksum;

  assign out_space     = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_full && out_space;
  assign s_axis_tready = !in_full || out_space;
  assign cfg_ready     = 1'b1;

  assign in_word.data = s_axis_tdata[DATA_W-1:0];
  assign in_word.keep = s_axis_tdata[IN_W-1:DATA_W];
  assign in_word.last = s_axis_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_checksum <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      skip_checksum <= cfg_data;
    end
  end

  ihc_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (s_axis_tvalid && s_axis_tready),
    .word_in (in_word),
    .take    (fire),
    .full    (in_full),
    .word_q  (held_word)
  );

  ihc_sum u_sum (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .skip_checksum (skip_checksum),
    .word          (held_word),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_space) begin
      m_axis_tvalid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign m_axis_tdata = {out_q.sums[3], out_q.sums[2], out_q.sums[1], out_q.sums[0],
                         out_q.keep, out_q.data};
  assign m_axis_tlast = out_q.last;
  assign m_axis_tuser = out_q.sums_valid;

  // A word leaving the input register always lands in the output register.
  `ASSERT_PROP(a_fire_fills_out, clk, rst, fire |=> m_axis_tvalid)
  // Lane sums are zero on every word that does not end the header.
  `ASSERT_NEVER(a_sums_zero, clk, rst,
                m_axis_tvalid && !m_axis_tuser && (m_axis_tdata[OUT_W-1:IN_W] != '0))

endmodule

// ===== hw/rtl/ihc_in_reg.sv =====
// Input register stage that holds one accepted word for the summing logic.
module ihc_in_reg import ihc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  in_word_t word_in,
  input  logic     take,
  output logic     full,
  output in_word_t word_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_q <= word_in;
    end
  end

endmodule

// ===== hw/rtl/ihc_sum.sv =====
// Lane summing logic with the per-packet header state.
module ihc_sum import ihc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  logic     skip_checksum,
  input  in_word_t word,
  output result_t  result
);

  lane_t [NUM_LANES-1:0] lane_sums;
  lane_t [NUM_LANES-1:0] lane_sums_next;
  lane_t [NUM_LANES-1:0] swapped;
  word_pos_t             word_pos;
  word_pos_t             word_pos_next;
  logic [HLEN_W-1:0]     header_left;
  logic [HLEN_W-1:0]     header_left_next;
  logic [NUM_LANES-1:0]  add_en;
  logic                  valid;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      swapped[i] = {word.data[LANE_W*i +: 8], word.data[LANE_W*i+8 +: 8]};
    end
  end

  always_comb begin
    add_en           = '0;
    valid            = 1'b0;
    header_left_next = header_left;
    word_pos_next    = word_pos;
    case (word_pos)
      WS_FIRST: begin
        add_en           = '1;
        header_left_next = word.data[HLEN_W-1:0] - HLEN_W'(2);
        word_pos_next    = WS_SECOND;
      end
      WS_SECOND: begin
        add_en           = '1;
        // Lane 1 of the second word carries the checksum field itself.
        add_en[1]        = !skip_checksum;
        header_left_next = header_left - HLEN_W'(2);
        word_pos_next    = WS_REST;
      end
      WS_REST: begin
        if (header_left == HLEN_W'(1)) begin
          add_en[1:0]      = 2'b11;
          valid            = 1'b1;
          header_left_next = '0;
        end else if (header_left != '0) begin
          add_en           = '1;
          valid            = (header_left == HLEN_W'(2));
          header_left_next = header_left - HLEN_W'(2);
        end
      end
      default: begin
        word_pos_next = WS_REST;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_sums_next[i] = add_en[i] ? ones_add(lane_sums[i], swapped[i]) : lane_sums[i];
    end
  end

  always_comb begin
    result.data       = word.data;
    result.keep       = word.keep;
    result.last       = word.last;
    result.sums_valid = valid;
    result.sums       = valid ? lane_sums_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_sums <= '0;
      word_pos  <= WS_FIRST;
    end else if (fire) begin
      if (word.last) begin
        lane_sums <= '0;
        word_pos  <= WS_FIRST;
      end else begin
        lane_sums <= lane_sums_next;
        word_pos  <= word_pos_next;
      end
    end
  end

  // The header count is always loaded by a first word before it is read.
  always_ff @(posedge clk) begin
    if (fire) begin
      header_left <= header_left_next;
    end
  end

endmodule

// ===== test/ipv4_header_checksum_lanes_checker.sv =====
// Checker that predicts and compares every output word of the IPv4 header checksum lane block.
module ipv4_header_checksum_lanes_checker import ihc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  // Fields from bit 0: data_in[63:0], keep_in[71:64].
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             s_axis_tlast,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // Fields from bit 0: data_out[63:0], keep_out[71:64], lane_sum_0..lane_sum_3.
  input  logic [OUT_W-1:0] m_axis_tdata,
  input  logic             m_axis_tlast,
  // Fields from bit 0: sums_valid.
  input  logic             m_axis_tuser,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_data,
  output int               fail_count,
  output int               pending,
  output int               words_checked,
  output int               sums_seen
);

  lane_t             lane_acc [NUM_LANES];
  word_pos_t         word_pos;
  logic [HLEN_W-1:0] hdr_left;
  logic              skip_csum;
  result_t           expected_words [$];
  result_t           want;
  lane_t             got_lane;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] exp_val);
    $display("Mismatch on output word %0d: %s is %h, expected %h",
             words_checked, what, got, exp_val);
    fail_count++;
  endtask

  // Byte-swap one lane into network order and fold it into its sum with end-around carry.
  task automatic fold_lane(input logic [DATA_W-1:0] w, input int i);
    logic [31:0] s;
    s = {16'h0, lane_acc[i]} + {16'h0, w[i*LANE_W +: 8], w[i*LANE_W+8 +: 8]};
    s = s + (s >> 16);
    lane_acc[i] = s[LANE_W-1:0];
  endtask

  task automatic predict_word(input logic [DATA_W-1:0] w, input logic [KEEP_W-1:0] k,
                              input logic l);
    result_t r;
    r.sums_valid = 1'b0;
    case (word_pos)
      WS_FIRST: begin
        for (int i = 0; i < NUM_LANES; i++) fold_lane(w, i);
        hdr_left = w[HLEN_W-1:0] - 4'd2;
        word_pos = WS_SECOND;
      end
      WS_SECOND: begin
        for (int i = 0; i < NUM_LANES; i++)
          if (!(skip_csum && i == 1)) fold_lane(w, i);
        hdr_left = hdr_left - 4'd2;
        word_pos = WS_REST;
      end
      default: begin
        if (hdr_left == 4'd1) begin
          // Only the lower half of this word still belongs to the header.
          fold_lane(w, 0);
          fold_lane(w, 1);
          hdr_left = 4'd0;
          r.sums_valid = 1'b1;
        end else if (hdr_left != 4'd0) begin
          for (int i = 0; i < NUM_LANES; i++) fold_lane(w, i);
          if (hdr_left == 4'd2) r.sums_valid = 1'b1;
          hdr_left = hdr_left - 4'd2;
        end
      end
    endcase
    r.data = w;
    r.keep = k;
    r.last = l;
    for (int i = 0; i < NUM_LANES; i++) r.sums[i] = r.sums_valid ? lane_acc[i] : '0;
    expected_words.push_back(r);
    if (l) begin
      for (int i = 0; i < NUM_LANES; i++) lane_acc[i] = '0;
      word_pos = WS_FIRST;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LANES; i++) lane_acc[i] = '0;
      word_pos = WS_FIRST;
      hdr_left = '0;
      skip_csum = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) skip_csum = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        predict_word(s_axis_tdata[DATA_W-1:0], s_axis_tdata[DATA_W +: KEEP_W], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unpredicted word, data", m_axis_tdata[DATA_W-1:0], '0);
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata[DATA_W-1:0] !== want.data)
            report_mismatch("data_out", m_axis_tdata[DATA_W-1:0], want.data);
          if (m_axis_tdata[DATA_W +: KEEP_W] !== want.keep)
            report_mismatch("keep_out", DATA_W'(m_axis_tdata[DATA_W +: KEEP_W]),
                            DATA_W'(want.keep));
          if (m_axis_tlast !== want.last)
            report_mismatch("last_out", DATA_W'(m_axis_tlast), DATA_W'(want.last));
          if (m_axis_tuser !== want.sums_valid)
            report_mismatch("sums_valid", DATA_W'(m_axis_tuser), DATA_W'(want.sums_valid));
          for (int i = 0; i < NUM_LANES; i++) begin
            got_lane = m_axis_tdata[DATA_W + KEEP_W + i*LANE_W +: LANE_W];
            if (got_lane !== want.sums[i])
              report_mismatch($sformatf("lane_sum_%0d", i), DATA_W'(got_lane),
                              DATA_W'(want.sums[i]));
          end
          if (want.sums_valid) sums_seen++;
        end
        words_checked++;
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== test/tb_ipv4_header_checksum_lanes_top.sv =====
// Testbench top: drives packets and register writes into the checksum lane block and gives the verdict.
module tb_ipv4_header_checksum_lanes_top import ihc_pkg::*;;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_WORDS  = 320;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic             m_axis_tuser;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_data = 1'b0;

  int fail_count;
  int pending;
  int words_checked;
  int sums_seen;
  int cycle_count = 0;
  int packets_sent = 0;
  int words_sent = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  ipv4_header_checksum_lanes_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  ipv4_header_checksum_lanes_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked),
    .sums_seen     (sums_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output side: a random stall before each word, with occasional stretches of none.
  initial begin
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_word(input logic [DATA_W-1:0] w, input logic [KEEP_W-1:0] k,
                           input logic l);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {k, w};
    s_axis_tlast  <= l;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    words_sent++;
  endtask

  // The header length in 32-bit words sits in bits 3:0 of the first word.
  task automatic send_packet(input logic [HLEN_W-1:0] ihl, input int n_words, input fill_t fill);
    logic [DATA_W-1:0] w;
    logic [KEEP_W-1:0] k;
    for (int i = 0; i < n_words; i++) begin
      case (fill)
        FILL_ONES: begin
          w = '1;
          k = '1;
        end
        FILL_ZEROS: begin
          w = '0;
          k = '0;
        end
        default: begin
          w = {$urandom, $urandom};
          k = KEEP_W'($urandom_range(0, 255));
        end
      endcase
      if (i == 0) begin
        w[HLEN_W-1:0] = ihl;
        if (fill == FILL_RANDOM && $urandom_range(0, 1) == 1) w[7:4] = 4'h4;
      end
      send_word(w, k, i == n_words - 1);
    end
    packets_sent++;
  endtask

  task automatic write_skip(input logic v);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed packets, plus short wrapping header lengths and packets cut inside the header.
  task automatic run_random(input int n);
    int done;
    int ihl;
    int len;
    int pick;
    fill_t fill;
    done = 0;
    while (done < n) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        ihl = ($urandom_range(0, 2) == 0) ? 5 : $urandom_range(5, 15);
        len = (ihl + 1) / 2 + $urandom_range(0, 4);
      end else if (pick < 85) begin
        ihl = $urandom_range(0, 4);
        len = $urandom_range(1, 10);
      end else begin
        ihl = $urandom_range(0, 15);
        len = $urandom_range(1, (ihl < 2) ? 1 : (ihl + 1) / 2);
      end
      pick = $urandom_range(0, 39);
      fill = (pick == 0) ? FILL_ONES : (pick == 1) ? FILL_ZEROS : FILL_RANDOM;
      send_packet(HLEN_W'(ihl), len, fill);
      done += len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_skip(1'b0);
    // Directed packets: a typical five-word header, all-ones with the longest header,
    // a four-word header that never gives final sums, a lone word, a packet that ends
    // inside its header, and an all-zero word stream whose header length wraps.
    send_packet(4'd5, 4, FILL_RANDOM);
    send_packet(4'd15, 8, FILL_ONES);
    send_packet(4'd4, 3, FILL_RANDOM);
    send_packet(4'd0, 1, FILL_ZEROS);
    send_packet(4'd6, 2, FILL_RANDOM);
    send_packet(4'd2, 8, FILL_ZEROS);

    write_skip(1'b1);
    run_random(PHASE_WORDS);
    write_skip(1'b0);
    run_random(PHASE_WORDS);
    write_skip(1'b1);
    run_random(PHASE_WORDS);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d packets in %0d words; %0d output words checked, %0d carried final sums.",
             packets_sent, words_sent, words_checked, sums_seen);
    $display("Covered both checksum skip settings, header lengths 0 to 15 and truncated headers.");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
